/* sv/teg_pkg.sv */
// Shared types, class codes and the code page table for the text encoding guesser.
// No dependencies; every other file refers to it by scoped names.
package teg_pkg;

  localparam int unsigned HeadLen = 6;

  typedef logic [3:0]  class_t;
  typedef logic [15:0] page_t;
  typedef logic [HeadLen-1:0][7:0] head_t;

  localparam class_t ClsAnsi      = 4'd0;
  localparam class_t ClsUtf8      = 4'd1;
  localparam class_t ClsUtf8Bom   = 4'd2;
  localparam class_t ClsUtf16LeBom = 4'd3;
  localparam class_t ClsUtf16BeBom = 4'd4;
  localparam class_t ClsUtf16Le   = 4'd5;
  localparam class_t ClsUtf16Be   = 4'd6;
  localparam class_t ClsOem850    = 4'd7;
  localparam class_t ClsLatin9    = 4'd8;

  // Scan results after the current byte, handed to the classifier.
  typedef struct packed {
    logic   decided;
    class_t verdict;
    logic   pending;
    logic   saw_multibyte;
  } scan_status_t;

  function automatic page_t page_of_class(input class_t cls);
    page_t pg;
    case (cls)
      ClsAnsi:       pg = 16'd0;
      ClsUtf8:       pg = 16'd65001;
      ClsUtf8Bom:    pg = 16'd65002;
      ClsUtf16LeBom: pg = 16'd65011;
      ClsUtf16BeBom: pg = 16'd65021;
      ClsUtf16Le:    pg = 16'd65010;
      ClsUtf16Be:    pg = 16'd65020;
      ClsOem850:     pg = 16'd850;
      ClsLatin9:     pg = 16'd28605;
      default:       pg = 16'd0;
    endcase
    return pg;
  endfunction

endpackage

/* sv/teg_if.sv */
// Valid/ready channel interfaces for the text encoding guesser.
// Depends on teg_pkg for the payload types.
interface teg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface teg_out_if;
  logic            valid;
  logic            ready;
  teg_pkg::class_t guess_class;
  teg_pkg::page_t  code_page;

  modport source (output valid, output guess_class, output code_page, input ready);
  modport sink   (input valid, input guess_class, input code_page, output ready);
endinterface

/* sv/teg_scan.sv */
// Per-stream state of the guesser: head byte buffer and the UTF-8 scan.
// Depends on teg_pkg. Shows the post-update state for the current byte.
module teg_scan (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_text,
  output teg_pkg::head_t        head_upd,
  output teg_pkg::scan_status_t status_upd
);

  teg_pkg::head_t  head_r,    head_nxt;
  logic [2:0]      idx_r,     idx_nxt;
  logic [1:0]      pend_r,    pend_nxt;
  logic            decided_r, decided_nxt;
  teg_pkg::class_t verdict_r, verdict_nxt;
  logic            multi_r,   multi_nxt;
  logic            stopped_r, stopped_nxt;

  always_comb begin
    head_nxt    = head_r;
    idx_nxt     = idx_r;
    pend_nxt    = pend_r;
    decided_nxt = decided_r;
    verdict_nxt = verdict_r;
    multi_nxt   = multi_r;
    stopped_nxt = stopped_r;

    if (idx_r < 3'(teg_pkg::HeadLen)) begin
      for (int i = 0; i < teg_pkg::HeadLen; i++) begin
        if (idx_r == 3'(i)) head_nxt[i] = data_byte;
      end
      idx_nxt = idx_r + 3'd1;
    end

    if (!stopped_r) begin
      if (pend_r != 2'd0) begin
        if ((data_byte & 8'hC0) == 8'h80) begin
          pend_nxt = pend_r - 2'd1;
          if (pend_r == 2'd1) multi_nxt = 1'b1;
        end else begin
          decided_nxt = 1'b1;
          verdict_nxt = teg_pkg::ClsAnsi;
          stopped_nxt = 1'b1;
        end
      end else if (data_byte == 8'h00) begin
        stopped_nxt = 1'b1;
      end else if (data_byte < 8'h80) begin
        // plain ASCII: nothing to record
      end else if (data_byte >= 8'h81 && data_byte <= 8'h90) begin
        decided_nxt = 1'b1;
        verdict_nxt = teg_pkg::ClsOem850;
        stopped_nxt = 1'b1;
      end else if (data_byte == 8'hA4) begin
        decided_nxt = 1'b1;
        verdict_nxt = teg_pkg::ClsLatin9;
        stopped_nxt = 1'b1;
      end else if (data_byte < 8'hC0 || data_byte >= 8'hF8) begin
        decided_nxt = 1'b1;
        verdict_nxt = teg_pkg::ClsAnsi;
        stopped_nxt = 1'b1;
      end else if (data_byte >= 8'hF0) begin
        pend_nxt = 2'd3;
      end else if (data_byte >= 8'hE0) begin
        pend_nxt = 2'd2;
      end else begin
        pend_nxt = 2'd1;
      end
    end
  end

  assign head_upd                 = head_nxt;
  assign status_upd.decided       = decided_nxt;
  assign status_upd.verdict       = verdict_nxt;
  assign status_upd.pending       = (pend_nxt != 2'd0);
  assign status_upd.saw_multibyte = multi_nxt;

  // Reset or final byte of a stream: drop everything so the next byte starts fresh.
  always_ff @(posedge clk) begin
    if (!rst_n || (step && end_of_text)) begin
      head_r    <= '0;
      idx_r     <= '0;
      pend_r    <= '0;
      decided_r <= 1'b0;
      verdict_r <= teg_pkg::ClsAnsi;
      multi_r   <= 1'b0;
      stopped_r <= 1'b0;
    end else if (step) begin
      head_r    <= head_nxt;
      idx_r     <= idx_nxt;
      pend_r    <= pend_nxt;
      decided_r <= decided_nxt;
      verdict_r <= verdict_nxt;
      multi_r   <= multi_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

/* sv/teg_classify.sv */
// Final decision: BOM and zero-pattern tests on the head bytes, then the scan verdict.
// Depends on teg_pkg. Purely combinational.
module teg_classify (
  input  teg_pkg::head_t        head,
  input  teg_pkg::scan_status_t status,
  output teg_pkg::class_t       guess_class,
  output teg_pkg::page_t        code_page
);

  teg_pkg::class_t cls;

  always_comb begin
    if (head[0] == 8'hEF && head[1] == 8'hBB && head[2] == 8'hBF) begin
      cls = teg_pkg::ClsUtf8Bom;
    end else if (head[0] == 8'hFF && head[1] == 8'hFE) begin
      cls = teg_pkg::ClsUtf16LeBom;
    end else if (head[0] == 8'hFE && head[1] == 8'hFF) begin
      cls = teg_pkg::ClsUtf16BeBom;
    end else if (head[1] == 8'h00 && head[3] == 8'h00 && head[5] == 8'h00) begin
      cls = teg_pkg::ClsUtf16Le;
    end else if (head[0] == 8'h00 && head[2] == 8'h00 && head[4] == 8'h00) begin
      cls = teg_pkg::ClsUtf16Be;
    end else if (status.decided) begin
      cls = (status.verdict <= teg_pkg::ClsLatin9) ? status.verdict : teg_pkg::ClsAnsi;
    end else if (status.pending) begin
      // stream ended inside a sequence
      cls = teg_pkg::ClsAnsi;
    end else if (status.saw_multibyte) begin
      cls = teg_pkg::ClsUtf8;
    end else begin
      cls = teg_pkg::ClsAnsi;
    end
  end

  assign guess_class = cls;
  assign code_page   = teg_pkg::page_of_class(cls);

endmodule

/* sv/text_encoding_guesser.sv */
// Top level of the text encoding guesser: input register, scan state, result register.
// Depends on teg_pkg, teg_if, teg_scan and teg_classify.
//
// Feed a text stream one byte per transaction on in_ch and mark the last byte with
// end_of_text; exactly one transaction on out_ch follows, carrying the guessed class
// and its code page. Bytes without end_of_text produce nothing. The block takes one
// byte per cycle unless a final byte waits for out_ch: a byte passes the input
// register, then the scan update and final decision combinationally; a final byte's
// result is registered and drives out_ch. A result held by a stalled out_ch holds
// the next final byte; later bytes wait. State clears after each final byte.
module text_encoding_guesser (
  input  logic       clk,
  input  logic       rst_n,
  teg_in_if.sink     in_ch,
  teg_out_if.source  out_ch
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_eot_r;

  logic            out_valid_r;
  teg_pkg::class_t out_class_r;
  teg_pkg::page_t  out_page_r;

  logic out_free;
  logic step;

  teg_pkg::head_t        head_upd;
  teg_pkg::scan_status_t status_upd;
  teg_pkg::class_t       cls;
  teg_pkg::page_t        page;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign step        = in_valid_r && (!in_eot_r || out_free);
  assign in_ch.ready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.data_byte;
      in_eot_r  <= in_ch.end_of_text;
    end
  end

  teg_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .data_byte   (in_byte_r),
    .end_of_text (in_eot_r),
    .head_upd    (head_upd),
    .status_upd  (status_upd)
  );

  teg_classify u_classify (
    .head        (head_upd),
    .status      (status_upd),
    .guess_class (cls),
    .code_page   (page)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && in_eot_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_eot_r) begin
      out_class_r <= cls;
      out_page_r  <= page;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.guess_class = out_class_r;
  assign out_ch.code_page   = out_page_r;

endmodule
